@@ rtl/emau_pkg.sv @@
// Package: shared types, codes and sizing for the endian memory access unit.
`timescale 1ns / 1ps

package emau_pkg;

    // Store capacity in bytes, kept as four byte-lane banks of words.
    localparam int MEM_BYTES = 65536;
    localparam int MEM_WORDS = (MEM_BYTES + 3) / 4;
    localparam int WADDR_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int LANES     = 4;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // Result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;

    // Register indexes
    localparam logic REG_BYTE_LIMIT = 1'b0;
    localparam logic REG_BIG_ENDIAN = 1'b1;

    localparam logic [16:0] BYTE_LIMIT_RST = 17'd65536;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } t_resp;

    typedef struct packed {
        logic [16:0] byte_limit;
        logic        big_endian;
    } t_cfg;

endpackage

@@ rtl/emau_regs.sv @@
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module emau_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output emau_pkg::t_cfg    o_cfg
);

    logic [16:0] r_byte_limit;
    logic        r_big_endian;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit <= emau_pkg::BYTE_LIMIT_RST;
            r_big_endian <= 1'b0;
        end else if (wr_en) begin
            if (paddr[2] == emau_pkg::REG_BYTE_LIMIT) begin
                r_byte_limit <= pwdata[16:0];
            end else begin
                r_big_endian <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == emau_pkg::REG_BYTE_LIMIT) begin
            prdata = {15'd0, r_byte_limit};
        end else begin
            prdata = {31'd0, r_big_endian};
        end
    end

    assign o_cfg.byte_limit = r_byte_limit;
    assign o_cfg.big_endian = r_big_endian;

endmodule

@@ rtl/emau_bank.sv @@
// One byte-lane bank: single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module emau_bank (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic                         i_re,
    input  logic [emau_pkg::WADDR_W-1:0] i_addr,
    input  logic [7:0]                   i_wdata,
    output logic [7:0]                   o_rdata
);

    logic [7:0] mem [emau_pkg::MEM_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

@@ rtl/endian_memory_access_unit_core.sv @@
// Top level: byte-addressed data memory with selectable byte order.
`timescale 1ns / 1ps

// Takes one access per clock: busy stays low, so a start is accepted in
// every cycle. The result of an access appears on o_resp with
// o_resp_valid high for exactly one cycle, after the stage-1 registers and
// the output register, and results leave in request order. The receiver
// cannot stall the unit and must take each result in its cycle. The delay
// comes from the synchronous read of the byte-lane banks plus the output
// register. Storage is four byte-wide banks indexed by word
// address; since halfwords and words must be aligned, any legal access
// touches one word, each byte landing in its own bank, so writes need no
// read-modify-write. A read issued the cycle after a write to the same
// word sees the new data. Stored bytes are undefined until written; there
// is no clearing pass after reset. Configuration (byte_limit at 0x0,
// big_endian at 0x4) should only change while no access is in flight.

module endian_memory_access_unit_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                start,
    output logic                busy,
    input  emau_pkg::t_req      i_req,
    // result channel
    output logic                o_resp_valid,
    output emau_pkg::t_resp     o_resp,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int LN = emau_pkg::LANES;

    emau_pkg::t_cfg cfg;

    emau_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy = 1'b0;

    // ---------------- stage 0: check and issue to banks ----------------
    logic        acc;
    logic [1:0]  last_ofs;     // number of bytes minus one
    logic [32:0] last_byte;
    logic [32:0] eff_limit;
    logic [1:0]  chk_status;
    logic        do_write;
    logic        do_read;

    assign acc = start && !busy;

    always_comb begin
        case (i_req.access_size)
            emau_pkg::SZ_BYTE: last_ofs = 2'd0;
            emau_pkg::SZ_HALF: last_ofs = 2'd1;
            emau_pkg::SZ_WORD: last_ofs = 2'd3;
            default:           last_ofs = 2'd0;
        endcase
    end

    // Effective limit is the smaller of byte_limit and capacity.
    assign eff_limit = (33'(cfg.byte_limit) > 33'(emau_pkg::MEM_BYTES)) ?
                       33'(emau_pkg::MEM_BYTES) : 33'(cfg.byte_limit);
    assign last_byte = {1'b0, i_req.address} + 33'(last_ofs);

    // Size code three fails alignment without a range check; otherwise
    // range comes first, then alignment.
    always_comb begin
        if (i_req.access_size inside {emau_pkg::SZ_BYTE, emau_pkg::SZ_HALF,
                                      emau_pkg::SZ_WORD}) begin
            if (last_byte >= eff_limit) begin
                chk_status = emau_pkg::ST_RANGE;
            end else if ((i_req.address[1:0] & last_ofs) != 2'd0) begin
                chk_status = emau_pkg::ST_ALIGN;
            end else begin
                chk_status = emau_pkg::ST_OK;
            end
        end else begin
            chk_status = emau_pkg::ST_ALIGN;
        end
    end

    assign do_write = acc && (chk_status == emau_pkg::ST_OK) &&
                      (i_req.opcode == emau_pkg::OP_WRITE);
    assign do_read  = acc && (chk_status == emau_pkg::ST_OK) &&
                      (i_req.opcode == emau_pkg::OP_READ);

    // Steer value bytes to banks. Value byte i goes to offset i
    // (little-endian) or last_ofs - i (big-endian) from the first byte.
    logic [LN-1:0]  bank_we;
    logic [7:0]     bank_wd [LN];
    logic [7:0]     bank_rd [LN];

    always_comb begin
        logic [1:0] v_bank;
        v_bank = 2'd0;
        for (int k = 0; k < LN; k++) begin
            bank_we[k] = 1'b0;
            bank_wd[k] = 8'd0;
        end
        for (int i = 0; i < LN; i++) begin
            if (2'(i) <= last_ofs) begin
                v_bank = i_req.address[1:0] +
                         (cfg.big_endian ? (last_ofs - 2'(i)) : 2'(i));
                bank_we[v_bank] = do_write;
                bank_wd[v_bank] = i_req.write_data[8*i +: 8];
            end
        end
    end

    for (genvar g = 0; g < LN; g++) begin : g_bank
        emau_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_re    (do_read),
            .i_addr  (i_req.address[emau_pkg::WADDR_W+1:2]),
            .i_wdata (bank_wd[g]),
            .o_rdata (bank_rd[g])
        );
    end

    // ---------------- stage 1: bank data returns ----------------
    logic       r_s1_valid;
    logic       r_s1_read;      // successful read: data comes from banks
    logic [1:0] r_s1_status;
    logic [1:0] r_s1_lane;
    logic [1:0] r_s1_last;
    logic       r_s1_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_read   <= do_read;
        r_s1_status <= chk_status;
        r_s1_lane   <= i_req.address[1:0];
        r_s1_last   <= last_ofs;
        r_s1_big    <= cfg.big_endian;
    end

    // Gather value bytes back from their banks, zero-extended.
    logic [31:0] n_rdata;

    always_comb begin
        logic [1:0] v_bank;
        v_bank  = 2'd0;
        n_rdata = 32'd0;
        for (int i = 0; i < LN; i++) begin
            if (2'(i) <= r_s1_last) begin
                v_bank = r_s1_lane + (r_s1_big ? (r_s1_last - 2'(i)) : 2'(i));
                n_rdata[8*i +: 8] = bank_rd[v_bank];
            end
        end
    end

    // ---------------- stage 2: output register ----------------
    logic            r_out_valid;
    emau_pkg::t_resp r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.read_data <= r_s1_read ? n_rdata : 32'd0;
        r_out.status    <= r_s1_status;
    end

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

    // ---------------- assertions ----------------
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid |-> $past(start, 2))
        else $error("result without an accepted request two cycles earlier");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid |-> (o_resp.status == emau_pkg::ST_OK ||
                          o_resp.status == emau_pkg::ST_RANGE ||
                          o_resp.status == emau_pkg::ST_ALIGN))
        else $error("illegal status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && o_resp.status != emau_pkg::ST_OK) |->
            (o_resp.read_data == 32'd0))
        else $error("failed access returned nonzero data");

    a_no_bad_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bank_we != '0) |-> (acc && chk_status == emau_pkg::ST_OK))
        else $error("bank written by a failed or absent access");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_read) |=> (o_resp.read_data == 32'd0))
        else $error("write or failed access returned data");

endmodule

@@ test/testbench.sv @@
// Testbench: endian memory access unit, self-checking against its own memory predictor.
`timescale 1ns / 1ps

// Drives accesses on the command port. Each access is accepted on an edge where start is
// high and busy is low. A predictor keeps its own byte store and its own copy of the
// configuration. At every accepted transfer it queues the expected result. A checker
// compares every o_resp_valid transfer, field by field, with the oldest queued result.
// Registers are written over the APB port only once every result has come back. Each
// write is read back.
//
// Successful reads only ever target bytes that the predictor knows were written. A random read
// that would succeed on an unwritten byte is turned into a write of the same bytes.

module testbench;

    localparam logic [1:0] SZ_RESERVED  = 2'd3;  // size code three, always misaligned
    localparam int         DRAIN_CYCLES = 4;     // covers the bank and output registers plus margin
    localparam int         PHASE_ITEMS  = 400;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             start     = 1'b0;
    emau_pkg::t_req   i_req     = '0;
    logic             psel      = 1'b0;
    logic             penable   = 1'b0;
    logic             pwrite    = 1'b0;
    logic [2:0]       paddr     = '0;
    logic [31:0]      pwdata    = '0;
    logic             busy;
    logic             o_resp_valid;
    emau_pkg::t_resp  o_resp;
    logic [31:0]      prdata;
    logic             pready;

    // predictor state
    logic [7:0]  store_bytes [0:emau_pkg::MEM_BYTES-1];
    bit          byte_written [0:emau_pkg::MEM_BYTES-1];
    logic [16:0] cfg_byte_limit = emau_pkg::BYTE_LIMIT_RST;
    logic        cfg_big_endian = 1'b0;

    emau_pkg::t_resp expected_resp_q [$];
    emau_pkg::t_resp oldest_resp;
    int              error_count = 0;
    int              idle_pct    = 0;   // chance in 100 that the sender idles a cycle

    endian_memory_access_unit_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .o_resp       (o_resp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Limit above capacity clamps to the store size.
    function automatic longint unsigned usable_bytes();
        if (32'(cfg_byte_limit) > emau_pkg::MEM_BYTES) begin
            return 64'(emau_pkg::MEM_BYTES);
        end
        return 64'(cfg_byte_limit);
    endfunction

    // Range check first (on the last byte touched), then alignment.
    // Size code three fails alignment without any range check.
    function automatic logic [1:0] access_status(input emau_pkg::t_req r);
        longint unsigned last_byte;
        int unsigned     nbytes;
        if (r.access_size == SZ_RESERVED) begin
            return emau_pkg::ST_ALIGN;
        end
        nbytes    = 1 << r.access_size;
        last_byte = longint'(r.address) + nbytes - 1;
        if (last_byte >= usable_bytes()) begin
            return emau_pkg::ST_RANGE;
        end
        if ((r.address & (nbytes - 1)) != 0) begin
            return emau_pkg::ST_ALIGN;
        end
        return emau_pkg::ST_OK;
    endfunction

    // Performs one access on the shadow store and returns its result.
    function automatic emau_pkg::t_resp apply_access(input emau_pkg::t_req r);
        emau_pkg::t_resp res;
        int unsigned     nbytes;
        int unsigned     lane;
        int unsigned     lane_addr;
        res.read_data = '0;
        res.status    = access_status(r);
        if (res.status == emau_pkg::ST_OK) begin
            nbytes = 1 << r.access_size;
            for (lane = 0; lane < nbytes; lane++) begin
                // lane 0 is the least significant byte of the value
                lane_addr = r.address + (cfg_big_endian ? (nbytes - 1 - lane) : lane);
                if (r.opcode == emau_pkg::OP_WRITE) begin
                    store_bytes[lane_addr]  = r.write_data[8*lane +: 8];
                    byte_written[lane_addr] = 1'b1;
                end else begin
                    res.read_data[8*lane +: 8] = store_bytes[lane_addr];
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: one transfer per o_resp_valid cycle, no back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_resp_valid) begin
            if (expected_resp_q.size() == 0) begin
                $display("%0t: unexpected result, read_data=%h status=%0d",
                         $time, o_resp.read_data, o_resp.status);
                error_count++;
            end else begin
                oldest_resp = expected_resp_q.pop_front();
                if (o_resp.read_data !== oldest_resp.read_data) begin
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, oldest_resp.read_data, o_resp.read_data);
                    error_count++;
                end
                if (o_resp.status !== oldest_resp.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, oldest_resp.status, o_resp.status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Every task starts and ends just after a rising edge.
    // start stays high between back-to-back transfers and is lowered
    // only for an idle cycle or a drain.
    // ------------------------------------------------------------------
    task automatic send_access(input emau_pkg::t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        expected_resp_q.push_back(apply_access(r));
    endtask

    // Stop sending and wait until every queued result has been seen.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_resp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then a read of the same register to confirm it.
    // psel stays high from the write into the read.
    task automatic write_register(input logic reg_index, input logic [31:0] value);
        logic [31:0] expected_value;
        logic [31:0] field_mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (reg_index == emau_pkg::REG_BYTE_LIMIT) begin
            cfg_byte_limit = value[16:0];
            expected_value = {15'd0, cfg_byte_limit};
            field_mask     = 32'h0001_FFFF;
        end else begin
            cfg_big_endian = value[0];
            expected_value = {31'd0, cfg_big_endian};
            field_mask     = 32'h0000_0001;
        end
        // read-back transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if ((prdata & field_mask) !== expected_value) begin
            $display("%0t: register %0d read-back, expected %h, actual %h",
                     $time, reg_index, expected_value, prdata & field_mask);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic emau_pkg::t_req make_access(input logic op, input logic [1:0] size,
                                                   input logic [31:0] addr,
                                                   input logic [31:0] data);
        emau_pkg::t_req r;
        r.opcode      = op;
        r.access_size = size;
        r.address     = addr;
        r.write_data  = data;
        return r;
    endfunction

    function automatic bit bytes_known(input emau_pkg::t_req r);
        int unsigned k;
        for (k = 0; k < (1 << r.access_size); k++) begin
            if (!byte_written[r.address + k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Random access: mostly a small hot window so reads hit written data,
    // plus the area around the limit, the whole store and any 32-bit address.
    function automatic emau_pkg::t_req make_random_access();
        emau_pkg::t_req r;
        int unsigned    nbytes;
        r.opcode      = 1'($urandom_range(1));
        r.access_size = ($urandom_range(15) == 0) ? SZ_RESERVED : 2'($urandom_range(2));
        r.write_data  = $urandom();
        case ($urandom_range(9))
            0:       r.address = $urandom();
            1, 2:    r.address = 32'(usable_bytes()) - 32'd8 + 32'($urandom_range(11));
            3:       r.address = $urandom_range(emau_pkg::MEM_BYTES - 1);
            default: r.address = $urandom_range(63);
        endcase
        if (r.access_size != SZ_RESERVED && $urandom_range(9) != 0) begin
            nbytes    = 1 << r.access_size;
            r.address = r.address & ~(nbytes - 1);
        end
        // a successful read may only touch bytes already written
        if (r.opcode == emau_pkg::OP_READ && access_status(r) == emau_pkg::ST_OK &&
            !bytes_known(r)) begin
            r.opcode = emau_pkg::OP_WRITE;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(5))
            0:       return emau_pkg::MEM_BYTES;
            1:       return 32'h0001_FFFF;   // above capacity
            2:       return emau_pkg::MEM_BYTES - 1;
            3:       return $urandom_range(4, 256);
            default: return $urandom_range(1, emau_pkg::MEM_BYTES);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: little-endian, full store.
    task automatic test_little_endian_directed();
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_WORD, 32'd0, 32'hFFFF_FFFF));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd0, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_BYTE, 32'd1, 32'hFFFF_FF5A));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_HALF, 32'd2, 32'hABCD_0000));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_HALF, 32'd0, 32'hFFFF_FFFF));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd0, 32'd0));
        // top of the store
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_WORD, 32'd65532,
                                32'h89AB_CDEF));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd65535, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_HALF, 32'd65534, 32'd0));
        // last byte past the limit: range wins over misalignment
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_HALF, 32'd65535, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd65534, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_WORD, 32'hFFFF_FFFC, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'hFFFF_FFFF, 32'd0));
        // misaligned, failed write leaves the store alone
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_HALF, 32'd1, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_WORD, 32'd2, 32'h1234_5678));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd0, 32'd0));
        // size code three: misaligned even far out of range
        send_access(make_access(emau_pkg::OP_READ,  SZ_RESERVED, 32'd0, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, SZ_RESERVED, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF));
    endtask

    task automatic test_big_endian_order();
        drain_results();
        write_register(emau_pkg::REG_BIG_ENDIAN, 32'd1);
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_WORD, 32'd16, 32'h1122_3344));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd16, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_HALF, 32'd18, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_HALF, 32'd20, 32'h0000_BEEF));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_HALF, 32'd22, 32'h0000_0000));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd20, 32'd0));
        drain_results();
        write_register(emau_pkg::REG_BIG_ENDIAN, 32'd0);
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd16, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd20, 32'd0));
    endtask

    task automatic test_limit_settings();
        drain_results();
        write_register(emau_pkg::REG_BYTE_LIMIT, 32'd0);   // nothing is in range
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd0, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_BYTE, 32'd0, 32'h0000_00FF));
        drain_results();
        write_register(emau_pkg::REG_BYTE_LIMIT, 32'd4);
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_WORD, 32'd0, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd4, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_HALF, 32'd3, 32'hFFFF_FFFF));
        drain_results();
        write_register(emau_pkg::REG_BYTE_LIMIT, 32'h0001_FFFF);   // clamps to the store size
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd65535, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd65536, 32'd0));
        send_access(make_access(emau_pkg::OP_WRITE, emau_pkg::SZ_WORD, 32'd65532,
                                32'h0000_0000));
        drain_results();
        write_register(emau_pkg::REG_BYTE_LIMIT, emau_pkg::MEM_BYTES - 1);
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd65534, 32'd0));
        send_access(make_access(emau_pkg::OP_READ,  emau_pkg::SZ_BYTE, 32'd65535, 32'd0));
        drain_results();
        write_register(emau_pkg::REG_BYTE_LIMIT, emau_pkg::MEM_BYTES);
    endtask

    // One random phase; halfway through the sender stops, lets every result
    // come back and flips the byte order.
    task automatic test_random_traffic(input int pct, input int count);
        int n;
        drain_results();
        write_register(emau_pkg::REG_BIG_ENDIAN, 32'($urandom_range(1)));
        write_register(emau_pkg::REG_BYTE_LIMIT, pick_limit());
        idle_pct = pct;
        for (n = 0; n < count; n++) begin
            if (n == count / 2) begin
                drain_results();
                write_register(emau_pkg::REG_BIG_ENDIAN, {31'd0, ~cfg_big_endian});
            end
            send_access(make_random_access());
        end
        idle_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_little_endian_directed();
        test_big_endian_order();
        test_limit_settings();
        test_random_traffic(0,  PHASE_ITEMS);
        test_random_traffic(75, PHASE_ITEMS);
        test_random_traffic(0,  PHASE_ITEMS);
        test_random_traffic(18, PHASE_ITEMS);
        drain_results();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
